FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define VSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define VSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/vsp_pkg.sv
// Types and constants shared by the version string parser modules.
package vsp_pkg;

  localparam int MAX_TEXT    = 32;
  localparam int CNT_W       = $clog2(MAX_TEXT + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_V    = 8'h76;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CL_DIGIT,
    CL_VEE,
    CL_DOT,
    CL_TERM,
    CL_OTHER
  } cls_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_BEGIN,
    PH_FIELD
  } phase_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
  } qword_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

FILE: design/vsp_front.sv
// Front end: take input bytes and classify them into queue words.
module vsp_front import vsp_pkg::*; (
  input  logic    in_valid,
  output logic    in_ready,
  input  logic [7:0] in_ch,
  input  q_stat_t q_stat,
  output logic    push,
  output qword_t  push_word
);

  logic [7:0] diff;

  assign diff     = in_ch - CH_ZERO;
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_word.digit = diff[3:0];
    priority if (in_ch == CH_NUL) begin
      push_word.cls = CL_TERM;
    end else if (in_ch >= CH_ZERO && in_ch <= CH_NINE) begin
      push_word.cls = CL_DIGIT;
    end else if (in_ch == CH_V) begin
      push_word.cls = CL_VEE;
    end else if (in_ch == CH_DOT) begin
      push_word.cls = CL_DOT;
    end else begin
      push_word.cls = CL_OTHER;
    end
  end

endmodule

FILE: design/vsp_queue.sv
// Short FIFO of classified words between front and back ends.
module vsp_queue import vsp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qword_t  push_word,
  input  logic    pop,
  output qword_t  pop_word,
  output q_stat_t q_stat
);

  qword_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_word     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: design/vsp_back.sv
// Back end: parse classified words and register the result word.
module vsp_back import vsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  q_stat_t     q_stat,
  input  qword_t      pop_word,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_major,
  output logic [31:0] out_minor,
  output logic [31:0] out_patch
);

  phase_t            phase_r, phase_nxt;
  logic [1:0]        fidx_r, fidx_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [31:0]       first_r, first_nxt;
  logic [31:0]       second_r, second_nxt;
  logic              lz_r, lz_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  status_t           err_r, err_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic [31:0]       major_r, minor_r, patch_r;

  logic              load;
  logic [35:0]       wide;
  logic              ovf;

  // acc*10 + d; anything above bit 31 is an overflow
  assign wide = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + 36'(pop_word.digit);
  assign ovf  = |wide[35:32];

  // Output control: pop words, load result on the terminator.
  always_comb begin
    pop  = !q_stat.empty &&
           (pop_word.cls != CL_TERM || !out_valid_r || out_ready);
    load = pop && (pop_word.cls == CL_TERM);
    priority if (cnt_r == CNT_W'(MAX_TEXT)) begin
      status_nxt = ST_FORMAT;
    end else if (err_r != ST_OK) begin
      status_nxt = err_r;
    end else if (phase_r == PH_FIELD && fidx_r == 2'd2) begin
      status_nxt = ST_OK;
    end else begin
      status_nxt = ST_FORMAT;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Parser next state.
  always_comb begin
    phase_nxt  = phase_r;
    fidx_nxt   = fidx_r;
    acc_nxt    = acc_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    lz_nxt     = lz_r;
    cnt_nxt    = cnt_r;
    err_nxt    = err_r;
    if (load) begin
      phase_nxt  = PH_START;
      fidx_nxt   = '0;
      acc_nxt    = '0;
      first_nxt  = '0;
      second_nxt = '0;
      lz_nxt     = 1'b0;
      cnt_nxt    = '0;
      err_nxt    = ST_OK;
    end else if (pop) begin
      if (cnt_r != CNT_W'(MAX_TEXT)) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      if (err_r == ST_OK) begin
        unique case (phase_r)
          PH_START, PH_BEGIN: begin
            if (phase_r == PH_START && pop_word.cls == CL_VEE) begin
              phase_nxt = PH_BEGIN;
            end else if (pop_word.cls == CL_DIGIT) begin
              acc_nxt   = 32'(pop_word.digit);
              lz_nxt    = (pop_word.digit == 4'd0);
              phase_nxt = PH_FIELD;
            end else begin
              err_nxt = ST_FORMAT;
            end
          end
          PH_FIELD: begin
            if (pop_word.cls == CL_DIGIT) begin
              if (lz_r) begin
                err_nxt = ST_FORMAT;
              end else if (ovf) begin
                err_nxt = ST_RANGE;
              end else begin
                acc_nxt = wide[31:0];
              end
            end else if (pop_word.cls == CL_DOT && fidx_r != 2'd2) begin
              if (fidx_r == 2'd0) begin
                first_nxt = acc_r;
              end else begin
                second_nxt = acc_r;
              end
              fidx_nxt  = fidx_r + 1'b1;
              acc_nxt   = '0;
              lz_nxt    = 1'b0;
              phase_nxt = PH_BEGIN;
            end else begin
              err_nxt = ST_FORMAT;
            end
          end
          default: begin
            err_nxt = ST_FORMAT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      fidx_r      <= '0;
      acc_r       <= '0;
      first_r     <= '0;
      second_r    <= '0;
      lz_r        <= 1'b0;
      cnt_r       <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      fidx_r      <= fidx_nxt;
      acc_r       <= acc_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      lz_r        <= lz_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_nxt;
      major_r  <= (status_nxt == ST_OK) ? first_r  : '0;
      minor_r  <= (status_nxt == ST_OK) ? second_r : '0;
      patch_r  <= (status_nxt == ST_OK) ? acc_r    : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_major  = major_r;
  assign out_minor  = minor_r;
  assign out_patch  = patch_r;

endmodule

FILE: design/version_string_parser_core.sv
// Top level of the semantic version core parser.
//
// Feed a version string one byte per input word; a zero byte ends it. The
// accepted form is an optional leading 'v' and three decimal fields joined
// by dots, e.g. "v1.20.3", with no empty field, no leading zero and no field
// above 4294967295. Each terminator yields exactly one result word carrying
// status (0 ok, 1 format error, 2 range error) and major/minor/patch, which
// read zero unless status is ok; other bytes yield nothing. The first error
// in the string decides the status, except that a string of 32 or more bytes
// before the terminator always reports a format error. After a terminator
// the parser is back at string start. Throughput is one byte per clock
// while the queue has room: each byte costs a single pass through the
// parser's multiply-by-ten-and-add step. A terminator's result word passes
// through the four-word queue, and the parser loads the output register on
// the edge that pops it. A stalled result word holds in the output register
// while parsing continues; input stalls only once the queue fills behind a
// terminator that cannot leave.
module version_string_parser_core import vsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_major,
  output logic [31:0] out_minor,
  output logic [31:0] out_patch
);

  q_stat_t q_stat;
  logic    push;
  qword_t  push_word;
  logic    pop;
  qword_t  pop_word;

  // Classify bytes and push them while the queue has room.
  vsp_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_word (push_word)
  );

  // Decouple byte intake from result backpressure.
  vsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .q_stat    (q_stat)
  );

  // Advance the parser and hold the result word until taken.
  vsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_word   (pop_word),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_major  (out_major),
    .out_minor  (out_minor),
    .out_patch  (out_patch)
  );

endmodule

FILE: design/vsp_checker.sv
// Port-level checks for the version string parser, bound to the top level.
`include "assert_macros.svh"

module vsp_checker import vsp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_major,
  input logic [31:0] out_minor,
  input logic [31:0] out_patch
);

  logic        out_stall;
  logic        fields_zero;
  logic [97:0] out_word;

  assign out_stall   = out_valid && !out_ready;
  assign fields_zero = (out_major == '0) && (out_minor == '0) && (out_patch == '0);
  assign out_word    = {out_status, out_major, out_minor, out_patch};

  `VSP_ASSERT(a_out_hold, out_stall |=> out_valid, "result word dropped while stalled")
  `VSP_ASSERT(a_out_stable, out_stall |=> $stable(out_word), "result word changed while stalled")
  `VSP_ASSERT(a_err_zero, out_valid && out_status != ST_OK |-> fields_zero, "fields nonzero on error")
  `VSP_ASSERT(a_status_code, out_valid |-> out_status <= ST_RANGE, "unknown status code")
  `VSP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result word right after reset")

endmodule

bind version_string_parser_core vsp_checker u_vsp_checker (.*);
